### rtl/sete_pkg.sv
// Shared types, constants and decode helpers for the sprite entry tile expander.
// No dependencies; imported by every module of the block except sete_checker.
package sete_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_DATA_W      = 9;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PAL_BANK = 2'd0;
    localparam t_cfg_idx CFG_MAX_X    = 2'd1;
    localparam t_cfg_idx CFG_MAX_Y    = 2'd2;

    localparam logic [8:0] MAX_X_RST = 9'd319;
    localparam logic [8:0] MAX_Y_RST = 9'd239;

    localparam logic [5:0] ZOOM_SHRINK [16] = '{
        6'd0,  6'd7,  6'd14, 6'd20, 6'd25, 6'd30, 6'd34, 6'd38,
        6'd42, 6'd46, 6'd49, 6'd52, 6'd54, 6'd57, 6'd59, 6'd61
    };

    // Decoded sprite entry, one queue slot.
    typedef struct packed {
        logic [12:0] code;
        logic [4:0]  palette;
        logic [10:0] base_x;
        logic [10:0] base_y;
        logic        flip_x;
        logic        flip_y;
        logic        zoom_on;
        logic [4:0]  step_x;
        logic [4:0]  step_y;
        logic [2:0]  wmax;    // width - 1
        logic [2:0]  hmax;    // height - 1
        logic [1:0]  pad;     // code skip after each row
    } t_desc;

    function automatic logic [4:0] zoom_step(input logic [3:0] nib);
        logic [5:0] shrink;
        shrink = ZOOM_SHRINK[nib];
        return 5'd16 - {2'b00, shrink[5:3]};
    endfunction

    function automatic logic [1:0] row_pad(input logic [2:0] wmax);
        logic [1:0] pad;
        case (wmax)
            3'd2:    pad = 2'd1;
            3'd4:    pad = 2'd3;
            3'd5:    pad = 2'd2;
            3'd6:    pad = 2'd1;
            default: pad = 2'd0;
        endcase
        return pad;
    endfunction

endpackage

### rtl/sprite_entry_tile_expander_unit.sv
// Channel   | direction | handshake              | payload
// entry in  | input     | i_push / o_full        | i_word_y_zoom, i_word_x_zoom,
//           |           |                        | i_word_control, i_word_code
// tiles out | output    | o_empty / i_pop        | o_tile_code .. o_last
// config    | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// The back-end sequencer issues one tile per cycle while the output register is
// empty or popped; it loads each entry of W x H tiles from the descriptor queue first.
// Disabled entries are dropped at the front and never reach the back end.
// Entries are accepted while the queue has room, even while tiles drain.
// Synchronous active-low reset empties the queue and the output register
// and restores the config registers.
// Top level: sete_front, sete_queue, sete_back; depends on sete_pkg.
module sprite_entry_tile_expander_unit #(
    parameter int QUEUE_DEPTH = sete_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  sete_pkg::t_cfg_idx              i_cfg_index,
    input  logic [sete_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [15:0]                     i_word_y_zoom,
    input  logic [15:0]                     i_word_x_zoom,
    input  logic [15:0]                     i_word_control,
    input  logic [15:0]                     i_word_code,
    input  logic                            i_pop,
    output logic                            o_empty,
    output logic [12:0]                     o_tile_code,
    output logic [4:0]                      o_palette,
    output logic signed [10:0]              o_pos_x,
    output logic signed [10:0]              o_pos_y,
    output logic                            o_flip_x,
    output logic                            o_flip_y,
    output logic                            o_zoom_on,
    output logic [4:0]                      o_step_x,
    output logic [4:0]                      o_step_y,
    output logic                            o_last
);
    import sete_pkg::*;

    t_desc fe_desc;
    t_desc q_desc;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;

    assign o_cfg_ready = 1'b1;
    assign o_full      = q_full;

    sete_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_push         (i_push),
        .i_word_y_zoom  (i_word_y_zoom),
        .i_word_x_zoom  (i_word_x_zoom),
        .i_word_control (i_word_control),
        .i_word_code    (i_word_code),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_desc         (fe_desc)
    );

    sete_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (fe_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_desc),
        .o_empty (q_empty)
    );

    sete_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (q_desc),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_tile_code (o_tile_code),
        .o_palette   (o_palette),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_flip_x    (o_flip_x),
        .o_flip_y    (o_flip_y),
        .o_zoom_on   (o_zoom_on),
        .o_step_x    (o_step_x),
        .o_step_y    (o_step_y),
        .o_last      (o_last)
    );

endmodule

### rtl/sete_front.sv
// Front end: config registers, entry accept and decode into a descriptor.
// Depends on sete_pkg; feeds sete_queue.
module sete_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  sete_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [sete_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_push,
    input  logic [15:0]                         i_word_y_zoom,
    input  logic [15:0]                         i_word_x_zoom,
    input  logic [15:0]                         i_word_control,
    input  logic [15:0]                         i_word_code,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output sete_pkg::t_desc                     o_desc
);
    import sete_pkg::*;

    logic       r_pal_bank;
    logic [8:0] r_max_x;
    logic [8:0] r_max_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_bank <= 1'b0;
            r_max_x    <= MAX_X_RST;
            r_max_y    <= MAX_Y_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAL_BANK: r_pal_bank <= i_cfg_data[0];
                CFG_MAX_X:    r_max_x    <= i_cfg_data[8:0];
                CFG_MAX_Y:    r_max_y    <= i_cfg_data[8:0];
                default:      ;
            endcase
        end
    end

    logic [9:0] bx_raw;
    logic [9:0] by_raw;
    logic [3:0] zx;
    logic [3:0] zy;

    assign bx_raw = {1'b0, i_word_x_zoom[8:0]} + 10'd6;
    assign by_raw = {1'b0, i_word_y_zoom[8:0]} + 10'd1;
    assign zx     = i_word_x_zoom[15:12];
    assign zy     = i_word_y_zoom[15:12];

    always_comb begin
        o_desc.code    = i_word_code[12:0];
        o_desc.palette = {r_pal_bank, i_word_control[3:0]};
        // past the visible edge the position wraps to negative
        o_desc.base_x  = (bx_raw > {1'b0, r_max_x}) ? ({1'b0, bx_raw} - 11'd512)
                                                     : {1'b0, bx_raw};
        o_desc.base_y  = (by_raw > {1'b0, r_max_y}) ? ({1'b0, by_raw} - 11'd512)
                                                     : {1'b0, by_raw};
        o_desc.flip_x  = i_word_control[11];
        o_desc.flip_y  = i_word_control[15];
        o_desc.zoom_on = (zx | zy) != 4'd0;
        o_desc.step_x  = zoom_step(zx);
        o_desc.step_y  = zoom_step(zy);
        o_desc.wmax    = i_word_control[10:8];
        o_desc.hmax    = i_word_control[14:12];
        o_desc.pad     = row_pad(i_word_control[10:8]);
    end

    // disabled entries are dropped here and never reach the back end
    assign o_q_push = i_push && !i_q_full && i_word_control[7];

endmodule

### rtl/sete_queue.sv
// Short descriptor queue between front and back end.
// Depends on sete_pkg for the descriptor type.
module sete_queue #(
    parameter int DEPTH = sete_pkg::QUEUE_DEPTH_DEF   // 2 or more
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sete_pkg::t_desc i_wdata,
    output logic            o_full,
    input  logic            i_pop,
    output sete_pkg::t_desc o_rdata,
    output logic            o_empty
);
    import sete_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc              r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/sete_back.sv
// Back end: walks rows and columns of one descriptor, one tile per cycle,
// into an output register that is empty or popped. Depends on sete_pkg; pops sete_queue.
module sete_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sete_pkg::t_desc    i_desc,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [12:0]        o_tile_code,
    output logic [4:0]         o_palette,
    output logic signed [10:0] o_pos_x,
    output logic signed [10:0] o_pos_y,
    output logic               o_flip_x,
    output logic               o_flip_y,
    output logic               o_zoom_on,
    output logic [4:0]         o_step_x,
    output logic [4:0]         o_step_y,
    output logic               o_last
);
    import sete_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_back_state;

    t_back_state r_state, n_state;
    t_desc       r_desc;
    logic [2:0]  r_col, n_col;
    logic [2:0]  r_row, n_row;
    logic [12:0] r_code, n_code;
    logic        r_out_valid, n_out_valid;

    logic        emit;
    logic        last_col;
    logic        last_row;
    logic [2:0]  cc;
    logic [2:0]  rr;
    logic [7:0]  off_x;
    logic [7:0]  off_y;

    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign emit     = (r_state == S_RUN) && (!r_out_valid || i_pop);
    assign last_col = r_col == r_desc.wmax;
    assign last_row = r_row == r_desc.hmax;
    assign cc       = r_desc.flip_x ? (r_desc.wmax - r_col) : r_col;
    assign rr       = r_desc.flip_y ? (r_desc.hmax - r_row) : r_row;
    assign off_x    = {5'd0, cc} * {3'd0, r_desc.step_x};
    assign off_y    = {5'd0, rr} * {3'd0, r_desc.step_y};

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_pop;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_RUN;
                    n_col   = '0;
                    n_row   = '0;
                    n_code  = i_desc.code;
                end
            end
            S_RUN: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    if (last_col) begin
                        n_col  = '0;
                        n_row  = r_row + 1'b1;
                        n_code = r_code + 13'd1 + {11'd0, r_desc.pad};
                        if (last_row) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_col  = r_col + 1'b1;
                        n_code = r_code + 13'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col  <= n_col;
        r_row  <= n_row;
        r_code <= n_code;
        if (o_q_pop) begin
            r_desc <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_tile_code <= r_code;
            o_palette   <= r_desc.palette;
            o_pos_x     <= r_desc.base_x + {3'd0, off_x};
            o_pos_y     <= r_desc.base_y + {3'd0, off_y};
            o_flip_x    <= r_desc.flip_x;
            o_flip_y    <= r_desc.flip_y;
            o_zoom_on   <= r_desc.zoom_on;
            o_step_x    <= r_desc.step_x;
            o_step_y    <= r_desc.step_y;
            o_last      <= last_col && last_row;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

### rtl/sete_checker.sv
// Port-level checks for the sprite entry tile expander, bound to the top level.
// No package dependency; watches the result side of the top-level ports.
module sete_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_pop,
    input logic                            o_empty,
    input logic [12:0]                     o_tile_code,
    input logic signed [10:0]              o_pos_x,
    input logic signed [10:0]              o_pos_y,
    input logic                            o_zoom_on,
    input logic [4:0]                      o_step_x,
    input logic [4:0]                      o_step_y,
    input logic                            o_last
);

    // a waiting item stays put until popped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_tile_code) && $stable(o_pos_x)
            && $stable(o_pos_y) && $stable(o_last)))
        else $error("waiting tile item changed before pop");

    a_step_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_step_x >= 5'd9 && o_step_x <= 5'd16))
        else $error("step_x out of range");

    a_step_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_step_y >= 5'd9 && o_step_y <= 5'd16))
        else $error("step_y out of range");

    // unzoomed sprites always use full 16-pixel pitch
    a_unzoomed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_zoom_on) |-> (o_step_x == 5'd16 && o_step_y == 5'd16))
        else $error("unzoomed tile with reduced step");

endmodule

bind sprite_entry_tile_expander_unit sete_checker u_sete_checker (.*);
